/* hw/rtl/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// ffra_pkg
// shared types, widths and codes of the first-fit range allocator
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int MAX_RANGES_DEF = 64;
  localparam int ADDR_BITS_DEF  = 29;

  localparam int SIZE_W     = 29;
  localparam int OFF_W      = 28;
  localparam int CNT_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int SHIFT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 29;
  localparam int ASZ_W      = 30;

  localparam logic [SIZE_W-1:0]  ARENA_MAX   = SIZE_W'(256 * 1024 * 1024);
  localparam logic [SHIFT_W-1:0] ALIGN_MAX   = SHIFT_W'(16);
  localparam logic [SHIFT_W-1:0] ALIGN_RESET = SHIFT_W'(8);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE       = 2'd0,
    STATUS_NO_SPACE   = 2'd1,
    STATUS_TABLE_FULL = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARENA = 1'b0,
    CFG_ALIGN = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_FIN,
    ST_RESP
  } state_t;

endpackage

/* hw/rtl/ffra_in_if.sv */
// ----------------------------------------------------------------------------
// ffra_in_if
// request channel: allocate or free items
// ----------------------------------------------------------------------------
interface ffra_in_if;
  import ffra_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [SIZE_W-1:0] size_bytes;
  logic [OFF_W-1:0]  free_offset;

  modport source (output valid, cmd, size_bytes, free_offset, input ready);
  modport sink   (input valid, cmd, size_bytes, free_offset, output ready);
endinterface

/* hw/rtl/ffra_out_if.sv */
// ----------------------------------------------------------------------------
// ffra_out_if
// result channel: one item per request
// ----------------------------------------------------------------------------
interface ffra_out_if;
  import ffra_pkg::*;

  logic                valid;
  logic                ready;
  logic [OFF_W-1:0]    result_offset;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    free_range_count;

  modport source (output valid, result_offset, status, free_range_count, input ready);
  modport sink   (input valid, result_offset, status, free_range_count, output ready);
endinterface

/* hw/rtl/ffra_ram.sv */
// ----------------------------------------------------------------------------
// ffra_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/first_fit_range_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_range_allocator_core
// first-fit allocator over one arena, free ranges kept sorted in a ram
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries allocate / free items (valid/ready), out_ch returns one
//   result item per request (offset, status, free range count).
//   cfg_we/cfg_idx/cfg_data write arena_bytes (index 0, also resets the
//   table to one range) or align_shift (index 1); only while idle.
// operation:
//   an item walks the range table one entry per cycle, the read port of
//   the range ram being the limit. allocate: scan up to the first fit,
//   then move the later entries down when that range empties. free: scan
//   the whole table, then move entries on insert or double merge. one
//   item is handled at a time.
// reset:
//   synchronous rst_n; afterwards the idle state rewrites entry 0 as
//   (0, arena_bytes), the same happens after an arena_bytes write.
// stalls:
//   the result sits in an output register; a new item is accepted while it
//   waits, the next result is held back until out_ch.ready.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_core #(
  parameter int MAX_RANGES = ffra_pkg::MAX_RANGES_DEF,
  parameter int ADDR_BITS  = ffra_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ffra_in_if.sink                        in_ch,
  ffra_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ffra_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ffra_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ffra_pkg::*;

  localparam int AW  = ADDR_BITS;
  localparam int DW  = 2 * AW;
  localparam int IW  = $clog2(MAX_RANGES + 1);   // counts and loop indices
  localparam int RAW = $clog2(MAX_RANGES);       // ram address
  localparam int CW  = (AW + 1 > ASZ_W) ? AW + 1 : ASZ_W;  // compare width

  // control and configuration state
  state_t             state_r, state_nxt;
  logic               init_pend_r;
  logic [SIZE_W-1:0]  arena_r;
  logic [SHIFT_W-1:0] align_r;
  logic [IW-1:0]      count_r;
  logic [IW-1:0]      idx_r;

  // current item
  logic               cmd_r;
  logic [ASZ_W-1:0]   asz_r;
  logic [OFF_W-1:0]   off_r;

  // free neighbour search
  logic               lo_found_r, hi_found_r;
  logic [RAW-1:0]     lo_idx_r, hi_idx_r;
  logic [AW-1:0]      lo_start_r, lo_len_r, hi_len_r;
  logic [IW-1:0]      pos_r;

  // deferred write and result
  logic               wr_pend_r;
  logic [RAW-1:0]     wr_idx_r;
  logic [DW-1:0]      wr_data_r;
  logic               cnt_inc_r, cnt_dec_r;
  logic [OFF_W-1:0]   res_off_r;
  status_t            res_status_r;

  // output register
  logic                out_valid_r;
  logic [OFF_W-1:0]    out_off_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CNT_W-1:0]    out_cnt_r;

  // ram port
  logic           mem_we;
  logic [RAW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0]  mem_wdata, mem_rdata;

  ffra_ram #(.WIDTH(DW), .DEPTH(MAX_RANGES)) u_ranges (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---- per-entry evaluation ----
  logic [AW-1:0]    rd_start, rd_len;
  logic [IW:0]      idx_p1, hi_p1;
  logic [IW-1:0]    idx_m1, idx_m2, cnt_m1;
  logic             in_range, alloc_hit, alloc_empty;
  logic [CW-1:0]    end_w, rd_end;
  logic             lo_m, hi_m, below;
  logic             dn_done, up_done;
  logic             accept;
  logic [ASZ_W-1:0] unit, asz_in, size_ext;
  logic [SIZE_W-1:0] arena_wr;
  logic [SHIFT_W-1:0] align_wr;

  assign rd_start = mem_rdata[DW-1:AW];
  assign rd_len   = mem_rdata[AW-1:0];
  assign idx_p1   = (IW + 1)'(idx_r) + (IW + 1)'(1);
  assign hi_p1    = (IW + 1)'(hi_idx_r) + (IW + 1)'(1);
  assign idx_m1   = idx_r - IW'(1);
  assign idx_m2   = idx_r - IW'(2);
  assign cnt_m1   = count_r - IW'(1);
  assign in_range = idx_r < count_r;

  assign alloc_hit   = (cmd_r == CMD_ALLOC) && (CW'(rd_len) >= CW'(asz_r));
  assign alloc_empty = CW'(rd_len) == CW'(asz_r);

  assign end_w  = CW'(off_r) + CW'(asz_r);
  assign rd_end = CW'(rd_start) + CW'(rd_len);
  assign lo_m   = rd_end == CW'(off_r);
  assign hi_m   = CW'(rd_start) == end_w;
  assign below  = CW'(rd_start) < CW'(off_r);

  // shift loops stop after the last move
  assign dn_done = idx_p1 >= (IW + 1)'(count_r);
  assign up_done = idx_m1 == pos_r;

  assign accept = in_ch.valid && in_ch.ready;

  // size rounded to the alignment, zero takes one unit
  assign unit     = ASZ_W'(1) << align_r;
  assign size_ext = ASZ_W'(in_ch.size_bytes);
  assign asz_in   = (size_ext == '0) ? unit : ((size_ext + unit - ASZ_W'(1)) & ~(unit - ASZ_W'(1)));

  // configuration values clamped to their legal range
  always_comb begin
    arena_wr = cfg_data[SIZE_W-1:0];
    if (arena_wr == '0) begin
      arena_wr = SIZE_W'(1);
    end else if (arena_wr > ARENA_MAX) begin
      arena_wr = ARENA_MAX;
    end
    align_wr = cfg_data[SHIFT_W-1:0];
    if (align_wr > ALIGN_MAX) begin
      align_wr = ALIGN_MAX;
    end
  end

  // end-of-scan decisions for a free
  logic free_both, free_none_full, free_shift_up;
  assign free_both      = lo_found_r && hi_found_r;
  assign free_none_full = !lo_found_r && !hi_found_r && (count_r >= IW'(MAX_RANGES));
  assign free_shift_up  = !lo_found_r && !hi_found_r && !free_none_full && (pos_r < count_r);

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (in_range) begin
          if (alloc_hit) begin
            state_nxt = (alloc_empty && !dn_done) ? ST_SHIFT_DN : ST_FIN;
          end
        end else if (cmd_r == CMD_ALLOC) begin
          state_nxt = ST_FIN;
        end else if (free_both) begin
          state_nxt = (hi_p1 < (IW + 1)'(count_r)) ? ST_SHIFT_DN : ST_FIN;
        end else if (free_shift_up) begin
          state_nxt = ST_SHIFT_UP;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SHIFT_DN: begin
        if (dn_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_SHIFT_UP: begin
        if (up_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---- ram port and handshake ----
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    in_ch.ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = !init_pend_r;
        if (init_pend_r) begin
          // table back to the single range (0, arena)
          mem_we    = 1'b1;
          mem_wdata = {AW'(0), AW'(arena_r)};
        end
      end
      ST_SCAN: begin
        if (in_range) begin
          mem_raddr = idx_p1[RAW-1:0];
        end else if (free_both) begin
          mem_raddr = hi_p1[RAW-1:0];
        end else begin
          mem_raddr = cnt_m1[RAW-1:0];
        end
      end
      ST_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_m1[RAW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = idx_p1[RAW-1:0];
      end
      ST_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[RAW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = idx_m2[RAW-1:0];
      end
      ST_FIN: begin
        mem_we    = wr_pend_r;
        mem_waddr = wr_idx_r;
        mem_wdata = wr_data_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      init_pend_r <= 1'b1;
      arena_r     <= ARENA_MAX;
      align_r     <= ALIGN_RESET;
      count_r     <= IW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ARENA: begin
            arena_r     <= arena_wr;
            init_pend_r <= 1'b1;
          end
          CFG_ALIGN: align_r <= align_wr;
          default: ;
        endcase
      end else if (state_r == ST_IDLE && init_pend_r) begin
        init_pend_r <= 1'b0;
        count_r     <= IW'(1);
      end
      if (state_r == ST_FIN) begin
        if (cnt_inc_r) begin
          count_r <= count_r + IW'(1);
        end else if (cnt_dec_r) begin
          count_r <= cnt_m1;
        end
      end
      if (state_r == ST_RESP && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_r        <= in_ch.cmd;
          asz_r        <= asz_in;
          off_r        <= in_ch.free_offset;
          idx_r        <= '0;
          lo_found_r   <= 1'b0;
          hi_found_r   <= 1'b0;
          pos_r        <= '0;
          wr_pend_r    <= 1'b0;
          cnt_inc_r    <= 1'b0;
          cnt_dec_r    <= 1'b0;
          res_off_r    <= '0;
          res_status_r <= STATUS_DONE;
        end
      end
      ST_SCAN: begin
        if (in_range) begin
          idx_r <= idx_p1[IW-1:0];
          if (cmd_r == CMD_ALLOC) begin
            if (alloc_hit) begin
              res_off_r <= OFF_W'(rd_start);
              if (alloc_empty) begin
                cnt_dec_r <= 1'b1;
              end else begin
                wr_pend_r <= 1'b1;
                wr_idx_r  <= idx_r[RAW-1:0];
                wr_data_r <= {rd_start + AW'(asz_r), rd_len - AW'(asz_r)};
              end
            end
          end else begin
            if (below) begin
              pos_r <= pos_r + IW'(1);
            end
            if (!lo_found_r && lo_m) begin
              lo_found_r <= 1'b1;
              lo_idx_r   <= idx_r[RAW-1:0];
              lo_start_r <= rd_start;
              lo_len_r   <= rd_len;
            end
            if (!hi_found_r && hi_m) begin
              hi_found_r <= 1'b1;
              hi_idx_r   <= idx_r[RAW-1:0];
              hi_len_r   <= rd_len;
            end
          end
        end else if (cmd_r == CMD_ALLOC) begin
          res_status_r <= STATUS_NO_SPACE;
        end else if (free_both) begin
          // merged range lands one lower when the upper one sat before it
          idx_r     <= hi_p1[IW-1:0];
          cnt_dec_r <= 1'b1;
          wr_pend_r <= 1'b1;
          wr_idx_r  <= (lo_idx_r > hi_idx_r) ? lo_idx_r - RAW'(1) : lo_idx_r;
          wr_data_r <= {lo_start_r, lo_len_r + AW'(asz_r) + hi_len_r};
        end else if (lo_found_r) begin
          wr_pend_r <= 1'b1;
          wr_idx_r  <= lo_idx_r;
          wr_data_r <= {lo_start_r, lo_len_r + AW'(asz_r)};
        end else if (hi_found_r) begin
          wr_pend_r <= 1'b1;
          wr_idx_r  <= hi_idx_r;
          wr_data_r <= {AW'(off_r), hi_len_r + AW'(asz_r)};
        end else if (free_none_full) begin
          res_status_r <= STATUS_TABLE_FULL;
        end else begin
          idx_r     <= count_r;
          cnt_inc_r <= 1'b1;
          wr_pend_r <= 1'b1;
          wr_idx_r  <= pos_r[RAW-1:0];
          wr_data_r <= {AW'(off_r), AW'(asz_r)};
        end
      end
      ST_SHIFT_DN: idx_r <= idx_p1[IW-1:0];
      ST_SHIFT_UP: idx_r <= idx_m1;
      default: ;
    endcase
    if (state_r == ST_RESP && (!out_valid_r || out_ch.ready)) begin
      out_off_r    <= res_off_r;
      out_status_r <= res_status_r;
      out_cnt_r    <= CNT_W'(count_r);
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.result_offset    = out_off_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.free_range_count = out_cnt_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IW'(MAX_RANGES))
    else $error("range count above table size");

  a_shift_dn_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT_DN |-> idx_r < count_r)
    else $error("remove shift reads past the table");

  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SCAN)
    else $error("accepted item did not start a scan");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && res_status_r == STATUS_TABLE_FULL |-> !wr_pend_r && !cnt_inc_r)
    else $error("table full but a write is pending");
`endif
endmodule

/* dv/ffra_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffra_checker
// predicts each result item of the allocator from a model of its range table
// and compares every accepted result, field by field, in order
// ----------------------------------------------------------------------------
module ffra_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  ffra_in_if                              in_ch,
  ffra_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ffra_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_results
);
  import ffra_pkg::*;

  localparam int NR = MAX_RANGES_DEF;

  typedef struct packed {
    logic [OFF_W-1:0]    offset;
    status_t             status;
    logic [CNT_W-1:0]    count;
  } alloc_result_t;

  logic [SIZE_W-1:0]  arena;
  logic [SHIFT_W-1:0] shift;
  logic [SIZE_W-1:0]  rstart [NR];
  logic [SIZE_W-1:0]  rlen   [NR];
  int                 rcount;
  alloc_result_t      result_q [$];

  task automatic clear_table();
    for (int i = 0; i < NR; i++) begin
      rstart[i] = '0;
      rlen[i]   = '0;
    end
    rlen[0] = arena;
    rcount  = 1;
  endtask

  function automatic void drop_range(int idx);
    for (int i = idx; i + 1 < rcount; i++) begin
      rstart[i] = rstart[i+1];
      rlen[i]   = rlen[i+1];
    end
    rcount--;
    rstart[rcount] = '0;
    rlen[rcount]   = '0;
  endfunction

  function automatic alloc_result_t predict_item(logic cmd, logic [SIZE_W-1:0] sz,
                                                 logic [OFF_W-1:0] off);
    alloc_result_t r;
    longint unit, asz, fend;
    int lo, hi, pos;
    bit found;
    unit = longint'(1) << shift;
    asz  = (sz == 0) ? unit : ((longint'(sz) + unit - 1) & ~(unit - 1));
    r.offset = '0;
    r.status = STATUS_DONE;
    if (cmd == CMD_ALLOC) begin
      found = 0;
      for (int i = 0; i < rcount && !found; i++) begin
        if (longint'(rlen[i]) >= asz) begin
          found = 1;
          r.offset = rstart[i][OFF_W-1:0];
          rstart[i] = SIZE_W'(longint'(rstart[i]) + asz);
          rlen[i]   = SIZE_W'(longint'(rlen[i]) - asz);
          if (rlen[i] == 0) drop_range(i);
        end
      end
      if (!found) r.status = STATUS_NO_SPACE;
    end else begin
      lo = NR; hi = NR; pos = 0;
      fend = longint'(off) + asz;
      for (int i = 0; i < rcount; i++) begin
        if (longint'(rstart[i]) < longint'(off)) pos++;
        if (lo == NR && longint'(rstart[i]) + longint'(rlen[i]) == longint'(off)) lo = i;
        if (hi == NR && longint'(rstart[i]) == fend) hi = i;
      end
      if (lo < NR && hi < NR && lo != hi) begin
        rlen[lo] = SIZE_W'(longint'(rlen[lo]) + asz + longint'(rlen[hi]));
        drop_range(hi);
      end else if (lo < NR) begin
        rlen[lo] = SIZE_W'(longint'(rlen[lo]) + asz);
      end else if (hi < NR) begin
        rstart[hi] = SIZE_W'(off);
        rlen[hi]   = SIZE_W'(longint'(rlen[hi]) + asz);
      end else if (rcount >= NR) begin
        r.status = STATUS_TABLE_FULL;
      end else begin
        for (int i = rcount; i > pos; i--) begin
          rstart[i] = rstart[i-1];
          rlen[i]   = rlen[i-1];
        end
        rstart[pos] = SIZE_W'(off);
        rlen[pos]   = SIZE_W'(asz);
        rcount++;
      end
    end
    r.count = CNT_W'(rcount);
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t exp_r;
    alloc_result_t new_r;
    int errs;
    errs = 0;
    if (!rst_n) begin
      arena = ARENA_MAX;
      shift = ALIGN_RESET;
      clear_table();
      result_q.delete();
      fail_count      <= 0;
      pending_results <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_ARENA) begin
          arena = (cfg_data == 0) ? SIZE_W'(1) : (cfg_data > ARENA_MAX ? ARENA_MAX : cfg_data);
          clear_table();
        end else begin
          shift = (cfg_data[SHIFT_W-1:0] > ALIGN_MAX) ? ALIGN_MAX : cfg_data[SHIFT_W-1:0];
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        new_r = predict_item(in_ch.cmd, in_ch.size_bytes, in_ch.free_offset);
        result_q.insert(result_q.size(), new_r);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("result item with nothing expected");
          errs++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_ch.result_offset !== exp_r.offset) begin
            $error("result_offset: expected %0d actual %0d", exp_r.offset,
                   out_ch.result_offset);
            errs++;
          end
          if (out_ch.status !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, out_ch.status);
            errs++;
          end
          if (out_ch.free_range_count !== exp_r.count) begin
            $error("free_range_count: expected %0d actual %0d", exp_r.count,
                   out_ch.free_range_count);
            errs++;
          end
        end
      end
      fail_count      <= fail_count + errs;
      pending_results <= result_q.size();
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the first-fit range allocator
// ----------------------------------------------------------------------------
// directed allocate/free items at field extremes, then random phases over
// several arena and alignment settings; a checker beside the block predicts
// and compares every result item
// ----------------------------------------------------------------------------
module tb;
  import ffra_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending_results;
  bit                    stall_mode;

  ffra_in_if  in_ch ();
  ffra_out_if out_ch ();

  first_fit_range_allocator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  ffra_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side stalls: either a free-running random pattern or a long
  // stretch with ready held high
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_mode) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  int burst_left;

  // one item onto the request channel; waits for the handshake and leaves
  // valid up, the next item or the drain takes it down
  task automatic send_item(logic cmd, logic [SIZE_W-1:0] sz, logic [OFF_W-1:0] off);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.size_bytes  <= sz;
    in_ch.free_offset <= off;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    // room for the table clear that follows an arena write
    repeat (2) @(posedge clk);
  endtask

  // wait until every expected item has come back, then a settle margin
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  // one random phase: mostly allocations and frees of plausible blocks,
  // with some bogus frees and full-width noise
  task automatic random_phase(int n, int size_max);
    int pick;
    logic [SIZE_W-1:0] sz;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        sz = SIZE_W'($urandom_range(0, size_max));
        send_item(CMD_ALLOC, sz, OFF_W'($urandom));
      end else if (pick < 85) begin
        // free a small block at one of 65 offsets spaced size_max + 1 apart
        sz = SIZE_W'($urandom_range(0, size_max));
        send_item(CMD_FREE, sz, OFF_W'($urandom_range(0, 64) * (size_max + 1)));
      end else begin
        send_item(logic'($urandom_range(0, 1)), SIZE_W'($urandom), OFF_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_ARENA;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_ALLOC;
    in_ch.size_bytes  = '0;
    in_ch.free_offset = '0;
    stall_mode        = 1'b1;
    burst_left        = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // directed: reset settings, extremes of sizes and offsets
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_ALLOC, SIZE_W'(1), '1);
    send_item(CMD_ALLOC, SIZE_W'(256), '0);
    send_item(CMD_ALLOC, ARENA_MAX, '0);             // no space
    send_item(CMD_FREE, SIZE_W'(256), '0);           // no neighbour, new range
    send_item(CMD_FREE, SIZE_W'(256), OFF_W'(256));  // lower neighbour
    send_item(CMD_FREE, SIZE_W'(5), OFF_W'(4096));   // bogus overlap
    send_item(CMD_FREE, '1, '1);                     // wraps past arena
    send_item(CMD_ALLOC, '1, '1);
    drain_results();

    // tiny arena, no alignment: fill the table to force table full
    write_reg(CFG_ALIGN, CFG_DATA_W'(0));
    write_reg(CFG_ARENA, SIZE_W'(200));
    for (int i = 0; i < 70; i++) send_item(CMD_FREE, SIZE_W'(1), OFF_W'(1000 + 2 * i));
    send_item(CMD_ALLOC, SIZE_W'(200), '0);
    send_item(CMD_ALLOC, SIZE_W'(1), '0);
    drain_results();

    // out-of-range register values
    write_reg(CFG_ARENA, '0);
    write_reg(CFG_ALIGN, CFG_DATA_W'(31));
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_FREE, '0, '0);
    drain_results();
    write_reg(CFG_ARENA, '1);
    drain_results();

    // random phases over several settings
    stall_mode = 1'b0;
    write_reg(CFG_ALIGN, CFG_DATA_W'(4));
    write_reg(CFG_ARENA, SIZE_W'(4096));
    random_phase(110, 100);
    drain_results();
    stall_mode = 1'b1;
    write_reg(CFG_ALIGN, CFG_DATA_W'(0));
    write_reg(CFG_ARENA, SIZE_W'(512));
    random_phase(110, 8);
    drain_results();
    write_reg(CFG_ALIGN, CFG_DATA_W'(16));
    write_reg(CFG_ARENA, ARENA_MAX);
    random_phase(110, 300000);
    drain_results();
    write_reg(CFG_ALIGN, CFG_DATA_W'(8));
    write_reg(CFG_ARENA, SIZE_W'(1));
    random_phase(60, 2);
    drain_results();
    write_reg(CFG_ALIGN, CFG_DATA_W'(2));
    write_reg(CFG_ARENA, SIZE_W'(1000));
    random_phase(80, 40);
    drain_results();

    if (fail_count == 0) begin
      $display("first_fit_range_allocator_core regression: pass");
    end else begin
      $display("first_fit_range_allocator_core regression: fail");
    end
    $finish;
  end

  // generous ceiling on run length
  initial begin
    #2000000;
    $display("first_fit_range_allocator_core regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_in_if.sv
hw/rtl/ffra_out_if.sv
hw/rtl/ffra_ram.sv
hw/rtl/first_fit_range_allocator_core.sv
dv/ffra_checker.sv
dv/tb.sv
